// File: hw/rtl/rv32alu_pkg.sv
package rv32alu_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned IMM_W     = 12;
  localparam int unsigned S_DATA_W  = 32;
  localparam int unsigned M_DATA_W  = 72;

  // major opcodes and the standard and alternate funct7
  localparam logic [6:0] OPC_REG = 7'b0110011;
  localparam logic [6:0] OPC_IMM = 7'b0010011;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_STD  = 7'b0000000;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_SLL  = 4'd2,
    OP_SLT  = 4'd3,
    OP_XOR  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_SRL  = 4'd7,
    OP_SRA  = 4'd8,
    OP_ADDI = 4'd9,
    OP_SLTI = 4'd10,
    OP_ORI  = 4'd11,
    OP_XORI = 4'd12,
    OP_ANDI = 4'd13,
    OP_SLLI = 4'd14,
    OP_SRLI = 4'd15
  } op_t;

  typedef struct packed {
    logic [IMM_W-1:0]  imm;
    logic [REG_AW-1:0] rs2;
    logic [REG_AW-1:0] rs1;
    logic [REG_AW-1:0] rd;
    op_t               op;
  } instr_t;

  // register file read request, issued when a beat is taken
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] rs1;
    logic [REG_AW-1:0] rs2;
  } rf_rd_t;

  // register file write back from the execute stage
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

// File: hw/rtl/rv32alu_regfile.sv
module rv32alu_regfile (
  input  logic                                clk,
  input  logic                                rst,
  input  rv32alu_pkg::rf_rd_t                 rd_req,
  input  rv32alu_pkg::rf_wr_t                 wr,
  output logic [rv32alu_pkg::XLEN-1:0]        opa,
  output logic [rv32alu_pkg::XLEN-1:0]        opb
);

  logic [rv32alu_pkg::XLEN-1:0]     mem [rv32alu_pkg::NUM_REGS];
  logic [rv32alu_pkg::NUM_REGS-1:0] valid;

  logic [rv32alu_pkg::XLEN-1:0] rdata_a;
  logic [rv32alu_pkg::XLEN-1:0] rdata_b;
  logic                         ok_a;
  logic                         ok_b;
  logic                         fwd_a;
  logic                         fwd_b;
  logic [rv32alu_pkg::XLEN-1:0] fwd_val;

  // storage, no reset; entries never written are masked by valid
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.rd] <= wr.data;
    end
    if (rd_req.en) begin
      rdata_a <= mem[rd_req.rs1];
      rdata_b <= mem[rd_req.rs2];
      fwd_val <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ok_a  <= 1'b0;
      ok_b  <= 1'b0;
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.rd] <= 1'b1;
      end
      if (rd_req.en) begin
        ok_a  <= valid[rd_req.rs1];
        ok_b  <= valid[rd_req.rs2];
        // value being written back this same edge bypasses the array
        fwd_a <= wr.en && (wr.rd == rd_req.rs1);
        fwd_b <= wr.en && (wr.rd == rd_req.rs2);
      end
    end
  end

  assign opa = fwd_a ? fwd_val : (ok_a ? rdata_a : '0);
  assign opb = fwd_b ? fwd_val : (ok_b ? rdata_b : '0);

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> wr.rd != '0)
    else $error("write back to x0");

  a_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> valid[$past(wr.rd)])
    else $error("written entry not marked valid");

endmodule

// File: hw/rtl/rv32alu_core.sv
module rv32alu_core (
  input  rv32alu_pkg::instr_t            instr,
  input  logic [rv32alu_pkg::XLEN-1:0]   opa,
  input  logic [rv32alu_pkg::XLEN-1:0]   opb_reg,
  output logic [rv32alu_pkg::XLEN-1:0]   result,
  output logic [rv32alu_pkg::XLEN-1:0]   instr_word
);

  logic [rv32alu_pkg::XLEN-1:0]  immx;
  logic [rv32alu_pkg::XLEN-1:0]  opb;
  logic [4:0]                    sh;
  logic                          is_imm;
  logic                          is_shi;
  logic [2:0]                    f3;
  logic [6:0]                    f7;
  logic [rv32alu_pkg::IMM_W-1:0] imm_field;

  assign immx = {{(rv32alu_pkg::XLEN-rv32alu_pkg::IMM_W){instr.imm[rv32alu_pkg::IMM_W-1]}},
                 instr.imm};
  assign is_shi = (instr.op == rv32alu_pkg::OP_SLLI) || (instr.op == rv32alu_pkg::OP_SRLI);
  // addi and every op above it take the immediate
  assign is_imm = (instr.op >= rv32alu_pkg::OP_ADDI);
  assign opb = is_imm ? immx : opb_reg;
  assign sh  = opb[4:0];

  always_comb begin
    result = '0;
    f3     = rv32alu_pkg::F3_ADD;
    f7     = rv32alu_pkg::F7_STD;
    case (instr.op)
      rv32alu_pkg::OP_ADD: begin
        result = opa + opb;
      end
      rv32alu_pkg::OP_SUB: begin
        result = opa - opb;
        f7     = rv32alu_pkg::F7_ALT;
      end
      rv32alu_pkg::OP_SLL: begin
        result = opa << sh;
        f3     = rv32alu_pkg::F3_SLL;
      end
      rv32alu_pkg::OP_SLT: begin
        result = {31'd0, $signed(opa) < $signed(opb)};
        f3     = rv32alu_pkg::F3_SLT;
      end
      rv32alu_pkg::OP_XOR: begin
        result = opa ^ opb;
        f3     = rv32alu_pkg::F3_XOR;
      end
      rv32alu_pkg::OP_AND: begin
        result = opa & opb;
        f3     = rv32alu_pkg::F3_AND;
      end
      rv32alu_pkg::OP_OR: begin
        result = opa | opb;
        f3     = rv32alu_pkg::F3_OR;
      end
      rv32alu_pkg::OP_SRL: begin
        result = opa >> sh;
        f3     = rv32alu_pkg::F3_SR;
      end
      rv32alu_pkg::OP_SRA: begin
        result = $unsigned($signed(opa) >>> sh);
        f3     = rv32alu_pkg::F3_SR;
        f7     = rv32alu_pkg::F7_ALT;
      end
      rv32alu_pkg::OP_ADDI: begin
        result = opa + opb;
      end
      rv32alu_pkg::OP_SLTI: begin
        result = {31'd0, $signed(opa) < $signed(opb)};
        f3     = rv32alu_pkg::F3_SLT;
      end
      rv32alu_pkg::OP_ORI: begin
        result = opa | opb;
        f3     = rv32alu_pkg::F3_OR;
      end
      rv32alu_pkg::OP_XORI: begin
        result = opa ^ opb;
        f3     = rv32alu_pkg::F3_XOR;
      end
      rv32alu_pkg::OP_ANDI: begin
        result = opa & opb;
        f3     = rv32alu_pkg::F3_AND;
      end
      rv32alu_pkg::OP_SLLI: begin
        result = opa << sh;
        f3     = rv32alu_pkg::F3_SLL;
      end
      default: begin
        result = opa >> sh;
        f3     = rv32alu_pkg::F3_SR;
      end
    endcase
  end

  // immediate shifts encode only the 5-bit amount
  assign imm_field = is_shi ? {7'd0, instr.imm[4:0]} : instr.imm;

  assign instr_word = is_imm
    ? {imm_field, instr.rs1, f3, instr.rd, rv32alu_pkg::OPC_IMM}
    : {f7, instr.rs2, instr.rs1, f3, instr.rd, rv32alu_pkg::OPC_REG};

endmodule

// File: hw/rtl/rv32i_alu_execute_encode.sv
// rv32i alu execute and encode
// takes one decoded rv32i alu instruction per beat on the s_ channel, runs it
// against a 32 x 32-bit register file and returns the machine-code word, the
// result value and the destination register on the m_ channel
// s_tdata: op, rd, rs1, rs2, imm packed from bit 0 up; m_tdata: instr_word,
// result, dest packed from bit 0 up
// timing: the source registers are read at the accepting edge into registered
// read data; the alu and encoder sit between that stage and the output register,
// which raises m_tvalid when the execute stage advances
// throughput: one beat per cycle while m_tready stays high; a result written back in a cycle is
// bypassed to the instruction taken at the same edge, so dependent
// instructions issue back to back with no bubble
// reset clears all control state and marks every register invalid, so the
// whole file reads as zero right away without a clearing pass
// x0 always reads zero; writing x0 still returns the value but drops the write
// when the receiver stalls the output holds; the execute stage keeps its beat
// and s_tready drops only once both stages are full
module rv32i_alu_execute_encode (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // op[3:0], rd[8:4], rs1[13:9], rs2[18:14], imm[30:19], 0
  input  logic [rv32alu_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // instr_word[31:0], result[63:32], dest[68:64], 0
  output logic [rv32alu_pkg::M_DATA_W-1:0]   m_tdata
);

  // execute stage
  logic                         ex_valid;
  rv32alu_pkg::instr_t          ex_instr;
  logic                         ex_adv;
  logic                         take;

  // register file read data and alu outputs
  logic [rv32alu_pkg::XLEN-1:0] opa;
  logic [rv32alu_pkg::XLEN-1:0] opb;
  logic [rv32alu_pkg::XLEN-1:0] ex_result;
  logic [rv32alu_pkg::XLEN-1:0] ex_word;

  rv32alu_pkg::rf_rd_t          rd_req;
  rv32alu_pkg::rf_wr_t          wr;

  // output register
  logic [rv32alu_pkg::XLEN-1:0]   out_word;
  logic [rv32alu_pkg::XLEN-1:0]   out_result;
  logic [rv32alu_pkg::REG_AW-1:0] out_dest;

  rv32alu_pkg::instr_t in_instr;

  assign in_instr.op  = rv32alu_pkg::op_t'(s_tdata[3:0]);
  assign in_instr.rd  = s_tdata[8:4];
  assign in_instr.rs1 = s_tdata[13:9];
  assign in_instr.rs2 = s_tdata[18:14];
  assign in_instr.imm = s_tdata[30:19];

  // execute stage moves on when the output register is free or draining
  assign ex_adv   = ex_valid && (!m_tvalid || m_tready);
  assign s_tready = !ex_valid || ex_adv;
  assign take     = s_tvalid && s_tready;

  assign rd_req.en  = take;
  assign rd_req.rs1 = in_instr.rs1;
  assign rd_req.rs2 = in_instr.rs2;

  // write back when the result leaves the execute stage, never to x0
  assign wr.en   = ex_adv && (ex_instr.rd != '0);
  assign wr.rd   = ex_instr.rd;
  assign wr.data = ex_result;

  rv32alu_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_req (rd_req),
    .wr     (wr),
    .opa    (opa),
    .opb    (opb)
  );

  rv32alu_core u_core (
    .instr      (ex_instr),
    .opa        (opa),
    .opb_reg    (opb),
    .result     (ex_result),
    .instr_word (ex_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        ex_valid <= 1'b1;
      end else if (ex_adv) begin
        ex_valid <= 1'b0;
      end
      if (ex_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      ex_instr <= in_instr;
    end
    if (ex_adv) begin
      out_word   <= ex_word;
      out_result <= ex_result;
      out_dest   <= ex_instr.rd;
    end
  end

  assign m_tdata = {3'd0, out_dest, out_result, out_word};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !ex_valid |-> s_tready)
    else $error("input stalled with empty execute stage");

  a_adv_fills_output: assert property (@(posedge clk) disable iff (rst)
    ex_adv |=> m_tvalid)
    else $error("executed beat did not reach the output");

  a_opcode_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] == rv32alu_pkg::OPC_REG) ||
                 (m_tdata[6:0] == rv32alu_pkg::OPC_IMM))
    else $error("bad major opcode in output word");

endmodule
